>>> hw/rtl/frm_pkg.sv
// Shared types, constants and state encodings for the frame rate meter.
package frm_pkg;

	localparam int NUM_STREAMS = 6;
	localparam int SIDX_W      = 3;
	localparam int KIND_W      = 2;
	localparam int TS_W        = 48;
	localparam int FNUM_W      = 32;
	localparam int CNT_W       = 16;
	localparam int RATE_W      = 24;
	localparam int CFG_W       = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int PROD_W      = CNT_W + CFG_W;
	localparam int DIV_STEPS   = RATE_W;
	localparam int STEP_W      = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 2'd1;

	localparam logic [CFG_W-1:0] WINDOW_TICKS_RST = 24'd500000;
	localparam logic [CFG_W-1:0] TICKS_PER_SEC_RST = 24'd1000000;

	localparam logic [KIND_W-1:0] KIND_CAPTURE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DISPLAY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

	localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
	localparam logic [RATE_W-1:0] RATE_MAX  = '1;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_WAIT,
		ST_EMIT
	} seq_state_t;

	typedef enum logic [1:0] {
		RU_IDLE,
		RU_MUL,
		RU_CHK,
		RU_DIV
	} ru_state_t;

endpackage

>>> hw/rtl/frm_rate_unit.sv
// Shared rate unit: one multiply, a saturation check and a bit-serial division.
module frm_rate_unit
	import frm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CNT_W-1:0]  count,
	input  logic [TS_W-1:0]   elapsed,
	input  logic [CFG_W-1:0]  ticks_per_second,
	output logic              done,
	output logic [RATE_W-1:0] rate
);

	ru_state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [TS_W-1:0]   divisor_q;
	logic [PROD_W-1:0] prod_q;
	logic [TS_W-1:0]   rem_q;
	logic [RATE_W-1:0] low_q;
	logic [RATE_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic [RATE_W-1:0] rate_q;
	logic              done_q;

	logic [TS_W:0]     trial;
	logic              ge;
	logic              sat;

	// The numerator is prod * 256, so its top 24 bits are prod[39:16].
	// The quotient overflows 24 bits exactly when those bits reach the divisor.
	always_comb begin
		trial = {rem_q, low_q[RATE_W-1]};
		ge    = trial >= {1'b0, divisor_q};
		sat   = {{(TS_W-RATE_W){1'b0}}, prod_q[PROD_W-1:PROD_W-RATE_W]} >= divisor_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			RU_IDLE: if (start) state_d = RU_MUL;
			RU_MUL:  state_d = RU_CHK;
			RU_CHK:  state_d = sat ? RU_IDLE : RU_DIV;
			RU_DIV:  if (step_q == LAST_STEP) state_d = RU_IDLE;
			default: state_d = RU_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RU_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == RU_CHK) && sat) ||
				((state_q == RU_DIV) && (step_q == LAST_STEP));
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			RU_IDLE: begin
				if (start) begin
					count_q   <= count;
					divisor_q <= elapsed;
				end
			end
			RU_MUL: begin
				prod_q <= PROD_W'(count_q * ticks_per_second);
			end
			RU_CHK: begin
				rem_q  <= {{(TS_W-RATE_W){1'b0}}, prod_q[PROD_W-1:PROD_W-RATE_W]};
				low_q  <= {prod_q[PROD_W-RATE_W-1:0], 8'h00};
				step_q <= '0;
				if (sat) rate_q <= RATE_MAX;
			end
			RU_DIV: begin
				rem_q  <= ge ? TS_W'(trial - {1'b0, divisor_q}) : trial[TS_W-1:0];
				low_q  <= {low_q[RATE_W-2:0], 1'b0};
				quo_q  <= {quo_q[RATE_W-2:0], ge};
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) rate_q <= {quo_q[RATE_W-2:0], ge};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign rate = rate_q;

endmodule

>>> hw/rtl/frame_rate_meter_top.sv
// Top level of the frame rate meter: sequencer, per-stream state and result register.
//
// Usage: each input transfer (in_valid high, in_stall low) carries one frame
// event for a pipeline point (capture, display or write). The block meters six
// streams, a colour and a depth stream per point, and when any stream's window
// closes it emits one output transfer carrying all six rates in unsigned 16.8
// fps. Events with kind 3 are dropped without touching any stream state.
// Throughput: one event at a time, with in_stall high while it is worked on.
// An event that closes no window only evaluates its two streams, one that only
// restarts stale windows also loads the result register, and each rate that is
// computed (one multiply, a saturation check and 24 steps of the shared serial
// divider) adds a wait on the rate unit. A saturated rate skips the divider.
// Output: out_valid is set from the sequencer's emit step once the result
// register is free. A waiting result does not block new input; the
// sequencer only holds at its final step if the previous result is still there.
// The receiver may hold out_stall as long as it likes; the result holds.
// Configuration writes (cfg_valid and cfg_ready) are always taken; index 0 is
// window_ticks, index 1 ticks_per_second, other indexes are ignored.
// Reset clears all counters and windows, marks every stream as having seen no
// frame and restores the default window and tick rate.
module frame_rate_meter_top
	import frm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,

	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [KIND_W-1:0]        kind,
	input  logic [TS_W-1:0]          timestamp,
	input  logic                     has_image,
	input  logic                     has_aux,
	input  logic                     has_depth,
	input  logic signed [FNUM_W-1:0] color_frame_number,
	input  logic signed [FNUM_W-1:0] depth_frame_number,

	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [RATE_W-1:0]        capture_color_fps,
	output logic [RATE_W-1:0]        capture_depth_fps,
	output logic [RATE_W-1:0]        display_color_fps,
	output logic [RATE_W-1:0]        display_depth_fps,
	output logic [RATE_W-1:0]        write_color_fps,
	output logic [RATE_W-1:0]        write_depth_fps
);

	seq_state_t state_q, state_d;

	// Configuration registers.
	logic [CFG_W-1:0] window_ticks_q;
	logic [CFG_W-1:0] ticks_per_second_q;

	// Per-stream state, indexed by {kind, depth select}.
	logic [CNT_W-1:0]         frame_count_q  [NUM_STREAMS];
	logic [TS_W-1:0]          window_start_q [NUM_STREAMS];
	logic signed [FNUM_W-1:0] last_seen_q    [NUM_STREAMS];
	logic [RATE_W-1:0]        rate_value_q   [NUM_STREAMS];

	// The event being worked on.
	logic [KIND_W-1:0]        kind_q;
	logic [TS_W-1:0]          ts_q;
	logic                     color_q;
	logic                     depth_q;
	logic signed [FNUM_W-1:0] cfn_q;
	logic signed [FNUM_W-1:0] dfn_q;
	logic                     sel_q;
	logic                     upd_q;

	// Result register.
	logic                     out_valid_q;
	logic [RATE_W-1:0]        out_fps_q [NUM_STREAMS];

	logic                     in_xfer;
	logic                     out_free;

	// Evaluation of the current stream.
	logic [SIDX_W-1:0]        sidx;
	logic                     present;
	logic signed [FNUM_W-1:0] fnum;
	logic signed [FNUM_W-1:0] last;
	logic [TS_W-1:0]          elapsed;
	logic [CFG_W-1:0]         win;
	logic                     expired;
	logic                     is_new;
	logic                     restart;
	logic                     need_rate;
	logic [CNT_W-1:0]         cur_count;
	logic [CNT_W-1:0]         new_count;

	logic                     ru_start;
	logic                     ru_done;
	logic [RATE_W-1:0]        ru_rate;

	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		sidx      = {kind_q, sel_q};
		present   = sel_q ? depth_q : color_q;
		fnum      = sel_q ? dfn_q : cfn_q;
		last      = last_seen_q[sidx];
		cur_count = frame_count_q[sidx];
		elapsed   = ts_q - window_start_q[sidx];
		// A zero window behaves as a one-tick window, so the divisor is never zero.
		win       = (window_ticks_q == '0) ? CFG_W'(1) : window_ticks_q;
		expired   = elapsed >= {{(TS_W-CFG_W){1'b0}}, win};
		// A known frame number equal to the last one seen is a repeat.
		is_new    = present && !(!fnum[FNUM_W-1] && (fnum == last));
		// A missing stream that never saw a frame never restarts its window.
		restart   = expired && (present || !last[FNUM_W-1]);
		need_rate = is_new && expired;
		new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		ru_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && (kind != KIND_UNUSED)) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (need_rate) begin
					ru_start = 1'b1;
					state_d  = ST_WAIT;
				end else if (sel_q) begin
					state_d = (upd_q || restart) ? ST_EMIT : ST_IDLE;
				end
			end
			ST_WAIT: begin
				if (ru_done) state_d = sel_q ? ST_EMIT : ST_EVAL;
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Configuration writes; the port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ticks_q     <= WINDOW_TICKS_RST;
			ticks_per_second_q <= TICKS_PER_SEC_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WINDOW_TICKS:  window_ticks_q     <= cfg_data;
				CFG_TICKS_PER_SEC: ticks_per_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture of the accepted event. Aux data counts as colour except on write.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q  <= kind;
			ts_q    <= timestamp;
			color_q <= has_image || (has_aux && (kind != KIND_WRITE));
			depth_q <= has_depth;
			cfn_q   <= color_frame_number;
			dfn_q   <= depth_frame_number;
		end
	end

	// Stream state updates and sequencing flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
			upd_q <= 1'b0;
			for (int i = 0; i < NUM_STREAMS; i++) begin
				frame_count_q[i]  <= '0;
				window_start_q[i] <= '0;
				last_seen_q[i]    <= '1;
				rate_value_q[i]   <= '0;
			end
		end else begin
			if (in_xfer) begin
				sel_q <= 1'b0;
				upd_q <= 1'b0;
			end
			if (state_q == ST_EVAL) begin
				if (is_new && !fnum[FNUM_W-1]) last_seen_q[sidx] <= fnum;
				if (restart) begin
					frame_count_q[sidx]  <= '0;
					window_start_q[sidx] <= ts_q;
					upd_q                <= 1'b1;
				end else if (is_new) begin
					frame_count_q[sidx] <= new_count;
				end
				// A stale or repeating stream publishes a zero rate.
				if (restart && !is_new) rate_value_q[sidx] <= '0;
				if (!need_rate) sel_q <= 1'b1;
			end
			if ((state_q == ST_WAIT) && ru_done) begin
				rate_value_q[sidx] <= ru_rate;
				sel_q              <= 1'b1;
			end
		end
	end

	// Result register: loaded with a snapshot of all six rates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			for (int i = 0; i < NUM_STREAMS; i++) out_fps_q[i] <= rate_value_q[i];
		end
	end

	frm_rate_unit u_rate (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (ru_start),
		.count            (new_count),
		.elapsed          (elapsed),
		.ticks_per_second (ticks_per_second_q),
		.done             (ru_done),
		.rate             (ru_rate)
	);

	assign out_valid         = out_valid_q;
	assign capture_color_fps = out_fps_q[0];
	assign capture_depth_fps = out_fps_q[1];
	assign display_color_fps = out_fps_q[2];
	assign display_depth_fps = out_fps_q[3];
	assign write_color_fps   = out_fps_q[4];
	assign write_depth_fps   = out_fps_q[5];

endmodule

>>> dv/tb.sv
// Self-checking testbench for the frame rate meter: directed table, then randomized phases.
`timescale 1ns / 1ps

// The bench drives frame events into the meter and keeps its own copy of the
// six per-stream meters. It predicts, for each accepted event, whether a rate
// result is due and what all six published rates must be. A short table of
// directed events comes first. Some rows carry the expected rates typed in.
// Randomized phases follow, each under a new pair of register settings and
// one of four mixes of sender gaps and receiver stalls.
module tb
	import frm_pkg::*;
();

	localparam int SETTLE_CYCLES   = 100;
	localparam int EVENTS_PER_PHASE = 64;
	localparam int NUM_PHASES      = 8;
	localparam int PRINT_LIMIT     = 40;

	// The two spare register indexes must be ignored by the block.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	typedef logic [NUM_STREAMS-1:0][RATE_W-1:0] rate_set_t;

	// One row of stimulus. A row either rewrites both registers or sends one
	// frame event. Typed rows carry their own expected outcome.
	typedef struct packed {
		logic                     is_cfg;
		logic [CFG_W-1:0]         cfg_win;
		logic [CFG_W-1:0]         cfg_tps;
		logic [KIND_W-1:0]        kind;
		logic [TS_W-1:0]          ts;
		logic                     img;
		logic                     aux;
		logic                     dep;
		logic signed [FNUM_W-1:0] cfn;
		logic signed [FNUM_W-1:0] dfn;
		logic                     typed;
		logic                     fires;
		rate_set_t                rates;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]         cfg_data;

	logic                     in_valid;
	logic                     in_stall;
	logic [KIND_W-1:0]        kind;
	logic [TS_W-1:0]          timestamp;
	logic                     has_image;
	logic                     has_aux;
	logic                     has_depth;
	logic signed [FNUM_W-1:0] color_frame_number;
	logic signed [FNUM_W-1:0] depth_frame_number;

	logic                     out_valid;
	logic                     out_stall;
	logic [RATE_W-1:0]        capture_color_fps;
	logic [RATE_W-1:0]        capture_depth_fps;
	logic [RATE_W-1:0]        display_color_fps;
	logic [RATE_W-1:0]        display_depth_fps;
	logic [RATE_W-1:0]        write_color_fps;
	logic [RATE_W-1:0]        write_depth_fps;

	frame_rate_meter_top dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mirror of the block's registers and per-stream state.
	logic [CFG_W-1:0]         window_len;
	logic [CFG_W-1:0]         tick_rate;
	logic [CNT_W-1:0]         frames_in_window [NUM_STREAMS];
	logic [TS_W-1:0]          window_origin [NUM_STREAMS];
	logic signed [FNUM_W-1:0] newest_frame [NUM_STREAMS];
	logic [RATE_W-1:0]        held_rate [NUM_STREAMS];

	// Rate sets still owed by the block, oldest first.
	rate_set_t rates_due [$];

	int sender_idle_pct = 0;
	int stall_pct       = 0;
	int mismatches      = 0;
	int events_sent     = 0;
	int ignored_events  = 0;
	int results_checked = 0;
	int settings_used   = 0;

	string stream_name [NUM_STREAMS] = '{"capture_color", "capture_depth",
		"display_color", "display_depth", "write_color", "write_depth"};
	logic [KIND_W-1:0] kind_set [3] = '{KIND_CAPTURE, KIND_DISPLAY, KIND_WRITE};

	task automatic report_mismatch(string what, logic [RATE_W-1:0] got,
			logic [RATE_W-1:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT) begin
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		end
	endtask

	// Updates one stream for one event and tells whether its window closed.
	// A closed window either publishes a fresh rate or, for a stale or
	// repeating stream, publishes zero; both restart the window.
	function automatic logic advance_stream(int s, logic present,
			logic signed [FNUM_W-1:0] fnum, logic [TS_W-1:0] now);
		logic [TS_W-1:0] gap;
		logic [63:0]     span;
		logic [63:0]     product;
		logic [63:0]     quotient;
		logic            closed;
		span = (window_len == '0) ? 64'd1 : 64'(window_len);
		// The subtraction stays at timestamp width so a backwards step wraps.
		gap = now - window_origin[s];
		closed = 64'(gap) >= span;
		if (!present || (fnum >= 0 && fnum == newest_frame[s])) begin
			if (!present && newest_frame[s] < 0)
				return 1'b0;
			if (!closed)
				return 1'b0;
			held_rate[s] = '0;
			frames_in_window[s] = '0;
			window_origin[s] = now;
			return 1'b1;
		end
		if (fnum >= 0)
			newest_frame[s] = fnum;
		if (frames_in_window[s] != COUNT_MAX)
			frames_in_window[s] = frames_in_window[s] + 1'b1;
		if (!closed)
			return 1'b0;
		product = 64'(frames_in_window[s]) * 64'(tick_rate) * 64'd256;
		quotient = product / 64'(gap);
		held_rate[s] = (quotient > 64'(RATE_MAX)) ? RATE_MAX : quotient[RATE_W-1:0];
		frames_in_window[s] = '0;
		window_origin[s] = now;
		return 1'b1;
	endfunction

	// Works out what one accepted event does to the six meters.
	function automatic void meter_event(row_t r, output logic fired, output rate_set_t rates);
		logic colour;
		logic colour_done;
		logic depth_done;
		int   base;
		fired = 1'b0;
		rates = '0;
		if (r.kind == KIND_UNUSED)
			return;
		// Auxiliary data stands in for a colour image except at the write point.
		colour = r.img || (r.aux && r.kind != KIND_WRITE);
		base = int'(r.kind) * 2;
		colour_done = advance_stream(base, colour, r.cfn, r.ts);
		depth_done = advance_stream(base + 1, r.dep, r.dfn, r.ts);
		fired = colour_done || depth_done;
		for (int i = 0; i < NUM_STREAMS; i++)
			rates[i] = held_rate[i];
	endfunction

	// Stimulus table helpers.
	function automatic row_t frame_at(logic [KIND_W-1:0] k, logic [TS_W-1:0] ts,
			logic img, logic aux, logic dep,
			logic signed [FNUM_W-1:0] cfn, logic signed [FNUM_W-1:0] dfn);
		row_t r;
		r = '0;
		r.kind = k;
		r.ts = ts;
		r.img = img;
		r.aux = aux;
		r.dep = dep;
		r.cfn = cfn;
		r.dfn = dfn;
		return r;
	endfunction

	function automatic row_t quiet(row_t r);
		r.typed = 1'b1;
		r.fires = 1'b0;
		return r;
	endfunction

	function automatic row_t yields(row_t r, logic [RATE_W-1:0] cc, logic [RATE_W-1:0] cd,
			logic [RATE_W-1:0] dc, logic [RATE_W-1:0] dd,
			logic [RATE_W-1:0] wc, logic [RATE_W-1:0] wd);
		r.typed = 1'b1;
		r.fires = 1'b1;
		r.rates = {wd, wc, dd, dc, cd, cc};
		return r;
	endfunction

	function automatic row_t cfg_row(logic [CFG_W-1:0] win, logic [CFG_W-1:0] tps);
		row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.cfg_win = win;
		r.cfg_tps = tps;
		return r;
	endfunction

	// Presents one event, holding it steady until the block takes it, then
	// runs the predictor. The sender may idle at random first.
	task automatic send_event(row_t r, output logic fired, output rate_set_t rates);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= r.kind;
		timestamp <= r.ts;
		has_image <= r.img;
		has_aux <= r.aux;
		has_depth <= r.dep;
		color_frame_number <= r.cfn;
		depth_frame_number <= r.dfn;
		do @(posedge clk); while (in_stall);
		events_sent++;
		if (r.kind == KIND_UNUSED)
			ignored_events++;
		meter_event(r, fired, rates);
	endtask

	// Stops sending, waits for every owed result, then lets the block finish
	// any event that closed no window.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (rates_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_WINDOW_TICKS: window_len = value;
			CFG_TICKS_PER_SEC: tick_rate = value;
			default: ;
		endcase
	endtask

	// Rewrites both registers while the block is idle. The spare indexes get
	// random data on the way, which the block must drop.
	task automatic set_config(logic [CFG_W-1:0] win, logic [CFG_W-1:0] tps);
		drain_results();
		write_register(CFG_SPARE_2, CFG_W'($urandom));
		write_register(CFG_WINDOW_TICKS, win);
		write_register(CFG_TICKS_PER_SEC, tps);
		write_register(CFG_SPARE_3, CFG_W'($urandom));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	rate_set_t got_rates;
	rate_set_t want_rates;

	// Result checker, and the receiver's random stall for the next edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_rates = {write_depth_fps, write_color_fps, display_depth_fps,
				display_color_fps, capture_depth_fps, capture_color_fps};
			if (rates_due.size() == 0) begin
				report_mismatch("result with no event owing one", capture_color_fps, '0);
			end else begin
				want_rates = rates_due.pop_front();
				for (int i = 0; i < NUM_STREAMS; i++) begin
					if (got_rates[i] !== want_rates[i])
						report_mismatch(stream_name[i], got_rates[i], want_rates[i]);
				end
				results_checked++;
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin : stimulus
		row_t                     r;
		row_t                     script [$];
		logic                     fired;
		rate_set_t                rates;
		logic [TS_W-1:0]          now_ticks;
		logic [CFG_W-1:0]         win;
		logic [CFG_W-1:0]         tps;
		logic signed [FNUM_W-1:0] pick;
		int                       next_frame [NUM_STREAMS];
		int                       roll;
		int                       span;
		int                       counted;
		int                       s;

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_WINDOW_TICKS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		kind <= KIND_CAPTURE;
		timestamp <= '0;
		has_image <= 1'b0;
		has_aux <= 1'b0;
		has_depth <= 1'b0;
		color_frame_number <= '0;
		depth_frame_number <= '0;
		out_stall <= 1'b0;

		window_len = WINDOW_TICKS_RST;
		tick_rate = TICKS_PER_SEC_RST;
		for (int i = 0; i < NUM_STREAMS; i++) begin
			frames_in_window[i] = '0;
			window_origin[i] = '0;
			newest_frame[i] = -1;
			held_rate[i] = '0;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed events under the reset settings: a 500000 tick window at
		// one million ticks per second, so two frames in a window read 4.0 fps.
		script.push_back(quiet(frame_at(KIND_UNUSED, 48'hFFFF_FFFF_FFFF, 1, 1, 1,
			32'h7FFF_FFFF, 32'h7FFF_FFFF)));
		script.push_back(quiet(frame_at(KIND_CAPTURE, 48'd0, 1, 0, 1, 32'd0, 32'd0)));
		// Auxiliary data alone counts as colour at the capture point.
		script.push_back(yields(frame_at(KIND_CAPTURE, 48'd500000, 0, 1, 1, 32'd1, 32'd1),
			24'd1024, 24'd1024, 24'd0, 24'd0, 24'd0, 24'd0));
		// At the write point it does not, and neither stream has seen a frame.
		script.push_back(quiet(frame_at(KIND_WRITE, 48'd500000, 0, 1, 0, 32'd5, 32'd5)));
		// Unknown colour number and the largest depth number, one frame over
		// almost the whole timestamp range, so both rates round down to zero.
		script.push_back(yields(frame_at(KIND_DISPLAY, 48'hFFFF_FFFF_FFFF, 1, 0, 1,
			32'hFFFF_FFFF, 32'h7FFF_FFFF), 24'd1024, 24'd1024, 24'd0, 24'd0, 24'd0, 24'd0));
		// Time wraps to zero one tick later; the depth repeat inside the window
		// does nothing.
		script.push_back(quiet(frame_at(KIND_DISPLAY, 48'd0, 1, 1, 1,
			32'h8000_0000, 32'h7FFF_FFFF)));
		// A repeated depth frame after the window closes publishes zero.
		script.push_back(yields(frame_at(KIND_DISPLAY, 48'd499999, 1, 0, 1,
			32'hFFFF_FFFE, 32'h7FFF_FFFF), 24'd1024, 24'd1024, 24'd1024, 24'd0, 24'd0, 24'd0));
		// Both capture streams go missing for a full window and read stale.
		script.push_back(yields(frame_at(KIND_CAPTURE, 48'd1000000, 0, 0, 0, 32'd9, 32'd9),
			24'd0, 24'd0, 24'd1024, 24'd0, 24'd0, 24'd0));
		script.push_back(quiet(frame_at(KIND_CAPTURE, 48'd1000001, 0, 0, 0, 32'd0, 32'd0)));
		// A zero window acts as one tick; with the top tick rate a one tick
		// window overflows the rate, which must saturate.
		script.push_back(cfg_row(24'd0, 24'hFF_FFFF));
		script.push_back(frame_at(KIND_WRITE, 48'd1000001, 1, 0, 1,
			32'h1234_5678, 32'h2468_ACE0));
		script.push_back(yields(frame_at(KIND_WRITE, 48'd1000002, 1, 1, 1,
			32'h1234_5679, 32'h2468_ACE1),
			24'd0, 24'd0, 24'd1024, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF));
		// A zero tick rate always reads zero.
		script.push_back(cfg_row(24'd1, 24'd0));
		script.push_back(yields(frame_at(KIND_WRITE, 48'd1000003, 1, 0, 1,
			32'h1234_567A, 32'h2468_ACE2), 24'd0, 24'd0, 24'd1024, 24'd0, 24'd0, 24'd0));
		// Longest window at the slowest tick rate, with alternating bit patterns.
		script.push_back(cfg_row(24'hFF_FFFF, 24'd1));
		script.push_back(frame_at(KIND_DISPLAY, 48'h5555_5555_5555, 1, 1, 1, 32'd3, 32'd3));
		script.push_back(frame_at(KIND_CAPTURE, 48'hAAAA_AAAA_AAAA, 0, 1, 0,
			32'h5555_5555, 32'hAAAA_AAAA));
		script.push_back(frame_at(KIND_WRITE, 48'hAAAA_AAAA_AAAA, 1, 0, 1,
			32'h5555_5555, -32'sd5));
		script.push_back(frame_at(KIND_CAPTURE, 48'hAAAB_AAAA_AAAA, 1, 1, 1,
			32'h5555_5556, 32'h0000_0001));
		script.push_back(cfg_row(WINDOW_TICKS_RST, TICKS_PER_SEC_RST));

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				set_config(script[i].cfg_win, script[i].cfg_tps);
			end else begin
				send_event(script[i], fired, rates);
				// Typed rows still run the predictor so its state stays current,
				// but the typed outcome is what the block is held to.
				if (script[i].typed) begin
					fired = script[i].fires;
					rates = script[i].rates;
				end
				if (fired)
					rates_due.push_back(rates);
			end
		end

		// Randomized phases. Each phase picks register settings and a traffic
		// mix: no idling, a sparse sender, a stalling receiver, then both.
		for (int i = 0; i < NUM_STREAMS; i++)
			next_frame[i] = $urandom_range(1000);
		now_ticks = TS_W'({$urandom, $urandom});
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase == 0) begin
				win = 24'd1;
				tps = 24'hFF_FFFF;
			end else if (phase == NUM_PHASES - 1) begin
				win = 24'hFF_FFFF;
				tps = 24'd1;
			end else begin
				win = phase[1] ? CFG_W'($urandom_range(1, 200))
					: CFG_W'($urandom_range(1000, 100000));
				tps = phase[0] ? CFG_W'($urandom_range(1, 24'hFF_FFFF))
					: CFG_W'($urandom_range(1, 5000));
			end
			set_config(win, tps);
			sender_idle_pct = (phase % 4 == 1) ? 57 : (phase % 4 == 3) ? 26 : 0;
			stall_pct = (phase % 4 == 2) ? 57 : (phase % 4 == 3) ? 26 : 0;
			span = (win == '0) ? 1 : int'(win);

			counted = 0;
			while (counted < EVENTS_PER_PHASE) begin
				r = '0;
				roll = $urandom_range(99);
				r.kind = (roll < 5) ? KIND_UNUSED : kind_set[$urandom_range(2)];

				// Mostly forward steps of up to half a window plus one tick, some
				// events at the same instant, and now and then a jump anywhere in the
				// timestamp range, which may run time backwards.
				roll = $urandom_range(99);
				if (roll < 4)
					now_ticks = TS_W'({$urandom, $urandom});
				else if (roll >= 12)
					now_ticks = now_ticks + TS_W'($urandom_range(span / 2 + 1));
				r.ts = now_ticks;

				r.img = ($urandom_range(99) < 75);
				r.aux = $urandom_range(1);
				r.dep = ($urandom_range(99) < 75);

				// Frame numbers mostly run in sequence per stream, with repeats,
				// unknown (negative) numbers and arbitrary values mixed in.
				for (int j = 0; j < 2; j++) begin
					s = (r.kind == KIND_UNUSED) ? j : int'(r.kind) * 2 + j;
					roll = $urandom_range(99);
					if (roll < 70) begin
						next_frame[s] = next_frame[s] + 1;
						pick = next_frame[s];
					end else if (roll < 82) begin
						pick = next_frame[s];
					end else if (roll < 90) begin
						pick = -int'($urandom_range(1, 1000));
					end else begin
						pick = $urandom;
					end
					if (j == 0)
						r.cfn = pick;
					else
						r.dfn = pick;
				end

				send_event(r, fired, rates);
				if (fired)
					rates_due.push_back(rates);
				if (r.kind != KIND_UNUSED) begin
					counted++;
					// Halfway through one phase the sender holds off until the
					// block has delivered everything it owes.
					if (phase == 3 && counted == EVENTS_PER_PHASE / 2)
						drain_results();
				end
			end
		end

		drain_results();
		mismatches += rates_due.size();

		$display("Sent %0d frame events (%0d of the unused kind) under %0d register settings,",
			events_sent, ignored_events, settings_used);
		$display("and checked %0d six-stream rate results.", results_checked);
		if (mismatches == 0) begin
			$display("PASS frame_rate_meter_top");
		end else begin
			$display("FAIL frame_rate_meter_top");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of the stimulus above.
	initial begin
		#4000000;
		$display("FAIL frame_rate_meter_top");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/frm_pkg.sv
hw/rtl/frm_rate_unit.sv
hw/rtl/frame_rate_meter_top.sv
dv/tb.sv
